FILE: src/mme_pkg.sv
package mme_pkg;

    localparam int MAX_DIM = 8;
    localparam int IDX_W   = 3;
    localparam int DIM_W   = 4;
    localparam int VAL_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] FUNC_WR_A    = 2'd0;
    localparam logic [1:0] FUNC_WR_B    = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;
    localparam logic [1:0] FUNC_NONE    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 3'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic [1:0]              func;
        logic [IDX_W-1:0]        row_index;
        logic [IDX_W-1:0]        col_index;
        logic signed [VAL_W-1:0] element_value;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    saturated;
        logic                    dim_error;
        logic                    last;
    } result_t;

    typedef struct packed {
        logic                    vld;
        logic                    first;
        logic                    lastk;
        logic [IDX_W-1:0]        k;
        logic signed [VAL_W-1:0] a;
    } feed_t;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_WAIT,
        ST_EMIT
    } state_t;

    function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (d > DIM_W'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

FILE: src/mme_cell.sv
module mme_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [mme_pkg::IDX_W-1:0]       wr_row,
    input  logic signed [mme_pkg::VAL_W-1:0] wr_data,
    input  mme_pkg::feed_t                  feed_in,
    output mme_pkg::feed_t                  feed_out,
    output mme_pkg::acc_t                   acc,
    output logic                            done
);
    import mme_pkg::*;

    logic signed [VAL_W-1:0]  b_reg [MAX_DIM];
    feed_t                    fwd_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     pvld_reg;
    logic                     pfirst_reg;
    logic                     plast_reg;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    logic                     done_reg;

    // this cell's column of B
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            b_reg[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg    <= '0;
            pvld_reg   <= 1'b0;
            pfirst_reg <= 1'b0;
            plast_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            fwd_reg    <= feed_in;
            pvld_reg   <= fwd_reg.vld;
            pfirst_reg <= fwd_reg.first;
            plast_reg  <= fwd_reg.lastk;
            done_reg   <= pvld_reg && plast_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= fwd_reg.a * b_reg[fwd_reg.k];
        if (pvld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    always_comb
    begin
        if (pfirst_reg)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    assign feed_out = fwd_reg;
    assign acc      = acc_reg;
    assign done     = done_reg;

endmodule

FILE: src/matrix_multiply_engine_unit.sv
// Matrix multiply engine, C = A x B on signed Q16.16 values.
// Command channel: cmd is taken when start is high and busy is low.
//   func 0/1 writes one element of A/B (one per cycle while idle, never busy).
//   func 2 computes C and emits it row-major on result, one element per
//   cycle while result_valid is high; last marks the final element.
// A dimension mismatch (a_cols != b_rows) gives one error result the
// cycle after the command, busy stays low.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while idle. cfg_ready is always high.
// A row of MAX_DIM MAC cells, one per column of C, passes each A element
// along the chain. Each row of C is fed as nk A elements (ST_FEED), waits
// in ST_WAIT until the last cell reports done, then emits nc results
// (ST_EMIT); busy is high from the compute command to the last result.
// Results cannot be stalled. Reset clears control and sets all dimensions
// to MAX_DIM; the element stores are undefined until written.
module matrix_multiply_engine_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mme_pkg::cmd_t                     cmd,
    output logic                              result_valid,
    output mme_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]         cfg_data
);
    import mme_pkg::*;

    logic [DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DIM_W-1:0] nr, nk, nc;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] col_reg, col_next;

    logic signed [VAL_W-1:0] store_a [1 << ADDR_W];
    logic signed [VAL_W-1:0] feed_a_reg;
    logic [IDX_W-1:0]        feed_k_reg;
    logic                    feed_vld_reg;
    logic                    feed_first_reg;
    logic                    feed_lastk_reg;
    logic  feed_en;

    feed_t chain [MAX_DIM+1];
    acc_t  accs  [MAX_DIM];
    logic  dones [MAX_DIM];

    logic    accept;
    logic    in_range;
    logic    res_vld_reg, res_vld_next;
    result_t res_reg, res_next;
    acc_t    sel_acc;
    logic    sum_ok;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = (DIM_W'(cmd.row_index) < DIM_W'(MAX_DIM))
                    && (DIM_W'(cmd.col_index) < DIM_W'(MAX_DIM));

    assign nr = clip_dim(a_rows_reg);
    assign nk = clip_dim(a_cols_reg);
    assign nc = clip_dim(b_cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg <= DIM_RESET;
            a_cols_reg <= DIM_RESET;
            b_rows_reg <= DIM_RESET;
            b_cols_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_A_ROWS: a_rows_reg <= cfg_data;
                REG_A_COLS: a_cols_reg <= cfg_data;
                REG_B_ROWS: b_rows_reg <= cfg_data;
                REG_B_COLS: b_cols_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && cmd.func == FUNC_WR_A && in_range)
        begin
            store_a[{cmd.row_index, cmd.col_index}] <= cmd.element_value;
        end
        feed_a_reg <= store_a[{row_reg, k_reg}];
        feed_k_reg <= k_reg;
    end

    assign feed_en = (state_reg == ST_FEED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_vld_reg   <= 1'b0;
            feed_first_reg <= 1'b0;
            feed_lastk_reg <= 1'b0;
        end
        else
        begin
            feed_vld_reg   <= feed_en;
            feed_first_reg <= feed_en && (k_reg == '0);
            feed_lastk_reg <= feed_en && (DIM_W'(k_reg) == nk - DIM_W'(1));
        end
    end

    assign chain[0] = '{vld: feed_vld_reg, first: feed_first_reg, lastk: feed_lastk_reg,
                        k: feed_k_reg, a: feed_a_reg};

    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        mme_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (accept && cmd.func == FUNC_WR_B && in_range
                       && cmd.col_index == IDX_W'(j)),
            .wr_row   (cmd.row_index),
            .wr_data  (cmd.element_value),
            .feed_in  (chain[j]),
            .feed_out (chain[j+1]),
            .acc      (accs[j]),
            .done     (dones[j])
        );
    end

    assign sel_acc = accs[col_reg];
    assign sum_ok  = (sel_acc[ACC_W-1:FRAC_W+VAL_W-1] == '0)
                  || (sel_acc[ACC_W-1:FRAC_W+VAL_W-1] == '1);

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        k_next       = k_reg;
        col_next     = col_reg;
        res_vld_next = 1'b0;
        res_next     = res_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && cmd.func == FUNC_COMPUTE)
                begin
                    if (a_cols_reg != b_rows_reg)
                    begin
                        res_vld_next = 1'b1;
                        res_next     = '0;
                        res_next.dim_error = 1'b1;
                        res_next.last      = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_FEED;
                        row_next   = '0;
                        k_next     = '0;
                    end
                end
            end
            ST_FEED:
            begin
                if (DIM_W'(k_reg) == nk - DIM_W'(1))
                begin
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next = k_reg + IDX_W'(1);
                end
            end
            ST_WAIT:
            begin
                if (dones[MAX_DIM-1])
                begin
                    state_next = ST_EMIT;
                    col_next   = '0;
                end
            end
            ST_EMIT:
            begin
                res_vld_next       = 1'b1;
                res_next.out_row   = row_reg;
                res_next.out_col   = col_reg;
                res_next.dim_error = 1'b0;
                res_next.saturated = !sum_ok;
                if (sum_ok)
                begin
                    res_next.out_value = sel_acc[FRAC_W+VAL_W-1:FRAC_W];
                end
                else if (sel_acc[ACC_W-1])
                begin
                    res_next.out_value = {1'b1, {(VAL_W-1){1'b0}}};
                end
                else
                begin
                    res_next.out_value = {1'b0, {(VAL_W-1){1'b1}}};
                end
                res_next.last = (DIM_W'(row_reg) == nr - DIM_W'(1))
                             && (DIM_W'(col_reg) == nc - DIM_W'(1));
                if (DIM_W'(col_reg) == nc - DIM_W'(1))
                begin
                    if (DIM_W'(row_reg) == nr - DIM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FEED;
                        row_next   = row_reg + IDX_W'(1);
                        k_next     = '0;
                    end
                end
                else
                begin
                    col_next = col_reg + IDX_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            k_reg       <= '0;
            col_reg     <= '0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            k_reg       <= k_next;
            col_reg     <= col_next;
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule

FILE: src/mme_checker.sv
module mme_assertions (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  result_valid,
    input mme_pkg::result_t      result
);
    import mme_pkg::*;

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.dim_error |-> result.last)
        else $error("error transaction not marked last");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.saturated |->
            (result.out_value == {1'b1, {(VAL_W-1){1'b0}}})
            || (result.out_value == {1'b0, {(VAL_W-1){1'b1}}}))
        else $error("saturated result not at a limit");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |-> !busy)
        else $error("busy after last result");

    a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a command");

endmodule

bind matrix_multiply_engine_unit mme_assertions u_mme_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);

FILE: dv/mme_checker.sv
module mme_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  mme_pkg::cmd_t                 cmd,
    input  logic                          result_valid,
    input  mme_pkg::result_t              result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]     cfg_data,
    output int                            errors,
    output int                            pending
);
    import mme_pkg::*;

    logic signed [VAL_W-1:0] mat_a [MAX_DIM*MAX_DIM];
    logic signed [VAL_W-1:0] mat_b [MAX_DIM*MAX_DIM];
    logic [DIM_W-1:0]        n_a_rows, n_a_cols, n_b_rows, n_b_cols;
    result_t                 product_q [$];

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    function automatic int dim_eff(logic [DIM_W-1:0] d);
        if (d == 0)
        begin
            return 1;
        end
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic void predict_product();
        int                      nr, nc, nk;
        logic signed [66:0]      acc;
        logic signed [66:0]      shifted;
        logic signed [63:0]      prod;
        result_t                 r;
        nr = dim_eff(n_a_rows);
        nc = dim_eff(n_b_cols);
        nk = dim_eff(n_a_cols);
        if (n_a_cols != n_b_rows)
        begin
            r = '0;
            r.dim_error = 1'b1;
            r.last      = 1'b1;
            product_q.push_back(r);
            return;
        end
        for (int i = 0; i < nr; i++)
        begin
            for (int j = 0; j < nc; j++)
            begin
                acc = '0;
                for (int k = 0; k < nk; k++)
                begin
                    prod = mat_a[i*MAX_DIM+k] * mat_b[k*MAX_DIM+j];
                    acc  = acc + prod;
                end
                shifted = acc >>> FRAC_W;
                r = '0;
                r.out_row = IDX_W'(i);
                r.out_col = IDX_W'(j);
                if (shifted > $signed(67'h0_7FFF_FFFF))
                begin
                    r.out_value = 32'h7FFF_FFFF;
                    r.saturated = 1'b1;
                end
                else if (shifted < -$signed(67'h0_8000_0000))
                begin
                    r.out_value = 32'h8000_0000;
                    r.saturated = 1'b1;
                end
                else
                begin
                    r.out_value = shifted[31:0];
                end
                r.last = (i == nr - 1) && (j == nc - 1);
                product_q.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(string name, longint e, longint a);
        if (e != a)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
            errors++;
        end
    endfunction

    always @(negedge clk)
    begin
        result_t e;
        if (!rst_n)
        begin
            n_a_rows = DIM_W'(MAX_DIM);
            n_a_cols = DIM_W'(MAX_DIM);
            n_b_rows = DIM_W'(MAX_DIM);
            n_b_cols = DIM_W'(MAX_DIM);
            product_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_A_ROWS: n_a_rows = cfg_data;
                    REG_A_COLS: n_a_cols = cfg_data;
                    REG_B_ROWS: n_b_rows = cfg_data;
                    REG_B_COLS: n_b_cols = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid)
            begin
                if (product_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, result);
                    errors++;
                end
                else
                begin
                    e = product_q.pop_front();
                    check_field("out_row", e.out_row, result.out_row);
                    check_field("out_col", e.out_col, result.out_col);
                    check_field("out_value", e.out_value, result.out_value);
                    check_field("saturated", e.saturated, result.saturated);
                    check_field("dim_error", e.dim_error, result.dim_error);
                    check_field("last", e.last, result.last);
                end
            end
            if (start && !busy)
            begin
                case (cmd.func)
                    FUNC_WR_A: mat_a[{cmd.row_index, cmd.col_index}] = cmd.element_value;
                    FUNC_WR_B: mat_b[{cmd.row_index, cmd.col_index}] = cmd.element_value;
                    FUNC_COMPUTE: predict_product();
                    default: ;
                endcase
            end
        end
        pending = product_q.size();
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;
    import mme_pkg::*;

    localparam int LIMIT = 1000000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    cmd_t                 cmd = '0;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;
    int                   errors;
    int                   pending;
    int                   cycles = 0;
    int                   idle_pct = 0;
    logic [DIM_W-1:0]     d_a_rows = DIM_RESET, d_a_cols = DIM_RESET;
    logic [DIM_W-1:0]     d_b_rows = DIM_RESET, d_b_cols = DIM_RESET;
    bit                   loaded_a [MAX_DIM*MAX_DIM];
    bit                   loaded_b [MAX_DIM*MAX_DIM];

    matrix_multiply_engine_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    mme_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int dim_eff(logic [DIM_W-1:0] d);
        if (d == 0)
        begin
            return 1;
        end
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_FFFF);
            3: return -$urandom_range(0, 32'h3_FFFF);
            default: return $urandom;
        endcase
    endfunction

    // leaves start high; the caller either issues again or drops it
    task automatic issue(logic [1:0] f, logic [2:0] r, logic [2:0] c, logic [31:0] v);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start         <= 1'b1;
        cmd.func      <= f;
        cmd.row_index <= r;
        cmd.col_index <= c;
        cmd.element_value <= v;
        @(negedge clk);
        while (busy)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
        if (f == FUNC_WR_A)
        begin
            loaded_a[{r, c}] = 1'b1;
        end
        if (f == FUNC_WR_B)
        begin
            loaded_b[{r, c}] = 1'b1;
        end
    endtask

    task automatic quiesce();
        start <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (MAX_DIM + 16) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    task automatic set_dims(logic [3:0] ar, logic [3:0] ac, logic [3:0] br, logic [3:0] bc);
        quiesce();
        cfg_write(REG_A_ROWS, ar);
        cfg_write(REG_A_COLS, ac);
        cfg_write(REG_B_ROWS, br);
        cfg_write(REG_B_COLS, bc);
        cfg_write(CFG_IDX_W'($urandom_range(4, 7)), DIM_W'($urandom));
        cfg_valid <= 1'b0;
        d_a_rows = ar;
        d_a_cols = ac;
        d_b_rows = br;
        d_b_cols = bc;
    endtask

    task automatic compute();
        int nr, nc, nk;
        nr = dim_eff(d_a_rows);
        nc = dim_eff(d_b_cols);
        nk = dim_eff(d_a_cols);
        if (d_a_cols == d_b_rows)
        begin
            for (int i = 0; i < nr; i++)
            begin
                for (int k = 0; k < nk; k++)
                begin
                    if (!loaded_a[i*MAX_DIM+k])
                    begin
                        issue(FUNC_WR_A, 3'(i), 3'(k), pick_value());
                    end
                end
            end
            for (int k = 0; k < nk; k++)
            begin
                for (int j = 0; j < nc; j++)
                begin
                    if (!loaded_b[k*MAX_DIM+j])
                    begin
                        issue(FUNC_WR_B, 3'(k), 3'(j), pick_value());
                    end
                end
            end
        end
        issue(FUNC_COMPUTE, 3'($urandom), 3'($urandom), $urandom);
    endtask

    initial
    begin
        logic [3:0] seg_dims [6][4];
        int         pick;
        seg_dims = '{'{2, 3, 3, 2}, '{0, 0, 0, 4}, '{15, 15, 15, 15},
                     '{3, 5, 5, 1}, '{4, 2, 3, 4}, '{8, 8, 8, 8}};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_dims(1, 1, 1, 1);
        issue(FUNC_WR_A, 0, 0, 32'h7FFF_FFFF);
        issue(FUNC_WR_B, 0, 0, 32'h7FFF_FFFF);
        compute();
        issue(FUNC_WR_A, 0, 0, 32'h8000_0000);
        compute();
        issue(FUNC_WR_B, 0, 0, 32'h8000_0000);
        compute();
        issue(FUNC_WR_A, 0, 0, 32'h0000_0001);
        issue(FUNC_WR_B, 0, 0, 32'hFFFF_FFFF);
        compute();
        issue(FUNC_NONE, 3'd7, 3'd7, 32'hFFFF_FFFF);
        issue(FUNC_WR_A, 7, 7, 32'h0001_0000);
        issue(FUNC_WR_B, 0, 0, 32'hFFFF_0000);
        compute();
        set_dims(0, 0, 0, 0);
        compute();
        set_dims(2, 3, 2, 2);
        compute();
        set_dims(2, 2, 2, 3);
        compute();

        for (int seg = 0; seg < 6; seg++)
        begin
            set_dims(seg_dims[seg][0], seg_dims[seg][1], seg_dims[seg][2], seg_dims[seg][3]);
            idle_pct = (seg < 2) ? 16 : (seg < 4) ? 80 : 0;
            for (int n = 0; n < 75; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    compute();
                end
                else if (pick < 11)
                begin
                    issue(FUNC_NONE, 3'($urandom), 3'($urandom), $urandom);
                end
                else
                begin
                    issue((pick < 55) ? FUNC_WR_A : FUNC_WR_B, 3'($urandom),
                          3'($urandom), pick_value());
                end
            end
            compute();
        end

        quiesce();
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
